// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held
`define CHK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion, also checked while reset is held
`define CHK_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/core/gspe_pkg.sv -----
// Types and constants shared by the gas sensor ppm estimator
package gspe_pkg;

  localparam int SUM_W = 21;
  localparam int CNT_W = 8;
  localparam int MV_W  = 12;
  localparam int NUM_W = 41;
  localparam int DEN_W = 45;
  localparam int QUO_W = 57;
  localparam int LX_W  = 48;

  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  localparam logic [18:0] LOG2_10_Q16 = 19'd217706;
  localparam logic signed [28:0] EXP_OFFSET = 29'sd262144;
  localparam logic signed [28:0] EXP_LIMIT  = 29'sd1572864;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SUPPLY  = 3'd0;
  localparam reg_idx_t REG_LOAD    = 3'd1;
  localparam reg_idx_t REG_CLEAN   = 3'd2;
  localparam reg_idx_t REG_ICEPT   = 3'd3;
  localparam reg_idx_t REG_SLOPE   = 3'd4;
  localparam reg_idx_t REG_DIVIDER = 3'd5;

  typedef struct packed {
    logic [12:0]        supply;
    logic [19:0]        load;
    logic [15:0]        cr;
    logic signed [15:0] b;
    logic signed [15:0] inv;
  } cfg_t;

  typedef struct packed {
    logic             calib;
    logic [SUM_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic [23:0] ppm;
    logic [23:0] ratio;
    logic [12:0] mean;
    logic        sat;
  } result_t;

endpackage

// ----- rtl/core/gspe_queue.sv -----
// Two-entry word queue
module gspe_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/gspe_front.sv -----
// Sample accumulator: sums samples and hands finished groups to the queue
module gspe_front #(
  parameter int CALIB_SAMPLES   = 200,
  parameter int MEASURE_SAMPLES = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     divider_enable,
  input  logic                     push,
  output logic                     full,
  input  logic [gspe_pkg::MV_W-1:0] in_sample_mv,
  input  logic                     job_full,
  output logic                     job_push,
  output gspe_pkg::job_t           job
);

  localparam logic [gspe_pkg::CNT_W-1:0] CAL_N  = gspe_pkg::CNT_W'(CALIB_SAMPLES);
  localparam logic [gspe_pkg::CNT_W-1:0] MEAS_N = gspe_pkg::CNT_W'(MEASURE_SAMPLES);

  logic [gspe_pkg::SUM_W-1:0] sum_r;
  logic [gspe_pkg::SUM_W-1:0] sum_nxt;
  logic [gspe_pkg::CNT_W-1:0] cnt_r;
  logic [gspe_pkg::CNT_W-1:0] cnt_nxt;
  logic                       cal_r;
  logic [12:0]                samp;
  logic                       accept;
  logic                       last;

  assign samp    = divider_enable ? {in_sample_mv, 1'b0} : {1'b0, in_sample_mv};
  assign sum_nxt = sum_r + gspe_pkg::SUM_W'(samp);
  assign cnt_nxt = cnt_r + 1'b1;
  assign last    = (cnt_nxt >= (cal_r ? MEAS_N : CAL_N));
  assign full    = job_full;
  assign accept  = push && !job_full;

  assign job_push  = accept && last;
  assign job.calib = !cal_r;
  assign job.sum   = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      cal_r <= 1'b0;
    end else if (accept) begin
      if (last) begin
        sum_r <= '0;
        cnt_r <= '0;
        cal_r <= 1'b1;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/gspe_div.sv -----
// Restoring divider, one quotient bit per cycle
module gspe_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gspe_pkg::QUO_W-1:0] dividend,
  input  logic [gspe_pkg::DEN_W-1:0] divisor,
  output logic                       done,
  output logic [gspe_pkg::QUO_W-1:0] quot
);

  localparam int QW = gspe_pkg::QUO_W;
  localparam int DW = gspe_pkg::DEN_W;

  logic          busy_r;
  logic          done_r;
  logic [5:0]    cnt_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  assign trial   = {rem_r, quo_r[QW-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign done    = done_r;
  assign quot    = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(QW - 1);
      end else if (busy_r) begin
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/gspe_back.sv -----
// Group evaluator: resistance, reference, ratio, log2 and exp2 sequencer
module gspe_back #(
  parameter int CALIB_SAMPLES   = 200,
  parameter int MEASURE_SAMPLES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gspe_pkg::cfg_t    cfg,
  input  logic              job_valid,
  input  gspe_pkg::job_t    job,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output gspe_pkg::result_t res
);

  localparam logic [7:0] CAL_N  = 8'(CALIB_SAMPLES);
  localparam logic [7:0] MEAS_N = 8'(MEASURE_SAMPLES);
  localparam int MEAN_RECIP_I = ((1 << 29) + MEASURE_SAMPLES - 1) / MEASURE_SAMPLES;
  localparam logic [29:0] MEAN_RECIP = 30'(MEAN_RECIP_I);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_PREP  = 17'h00002,
    S_MUL   = 17'h00004,
    S_DISP  = 17'h00008,
    S_CDIV  = 17'h00010,
    S_RDIV  = 17'h00040,
    S_LNORM = 17'h00080,
    S_LSQ   = 17'h00100,
    S_LEND  = 17'h00200,
    S_B2    = 17'h00400,
    S_EMUL  = 17'h00800,
    S_ECHK  = 17'h01000,
    S_XPRE  = 17'h02000,
    S_XSQ   = 17'h04000,
    S_XOUT  = 17'h08000,
    S_PUSH  = 17'h10000
  } state_t;

  state_t              state_r;
  logic                calib_r;
  logic [20:0]         sum_r;
  logic [20:0]         diff_r;
  logic [40:0]         num_r;
  logic [44:0]         den_r;
  logic [23:0]         ref_r;
  logic [12:0]         mean_r;
  logic [23:0]         ratio_r;
  logic [23:0]         ppm_r;
  logic                sat_r;
  logic [47:0]         lx_r;
  logic [5:0]          lk_r;
  logic [30:0]         m_r;
  logic [3:0]          li_r;
  logic [15:0]         frac_r;
  logic                lsel_r;
  logic [21:0]         lnum_r;
  logic signed [22:0]  l_r;
  logic signed [23:0]  d_r;
  logic signed [28:0]  t_r;
  logic [30:0]         y_r;
  logic [3:0]          ei_r;
  logic [63:0]         sx_r;
  logic [63:0]         sr_r;
  logic [4:0]          bi_r;

  logic [20:0]         full_mv;
  logic [20:0]         diff_c;
  logic [15:0]         cr_eff;
  logic [23:0]         r0_eff;
  logic [40:0]         num_c;
  logic [44:0]         den_c;
  logic [50:0]         mean_prod;
  logic                div_start;
  logic [56:0]         div_dvd;
  logic [44:0]         div_dvs;
  logic                div_done;
  logic [56:0]         div_quo;
  logic                quo_ovf;
  logic [61:0]         sq;
  logic [31:0]         sq_hi;
  logic [21:0]         lval;
  logic signed [22:0]  l_c;
  logic signed [34:0]  bprod;
  logic signed [22:0]  b2;
  logic signed [23:0]  d_c;
  logic signed [39:0]  eprod;
  logic signed [27:0]  e_c;
  logic signed [28:0]  t_c;
  logic [63:0]         bitv;
  logic [63:0]         cand;
  logic                sq_ge;
  logic [63:0]         sr_nxt;
  logic [31:0]         yd;
  logic [4:0]          shamt;
  logic [23:0]         ppm_c;

  assign full_mv   = 21'(cfg.supply) * 21'(calib_r ? CAL_N : MEAS_N);
  assign diff_c    = (full_mv > sum_r) ? full_mv - sum_r : 21'd0;
  assign cr_eff    = (cfg.cr == 16'd0) ? 16'd1 : cfg.cr;
  assign r0_eff    = (ref_r == 24'd0) ? 24'd1 : ref_r;
  assign num_c     = 41'(cfg.load) * 41'(diff_r);
  assign den_c     = calib_r ? 45'(sum_r) * 45'(cr_eff) : 45'(sum_r) * 45'(r0_eff);
  assign mean_prod = 51'(sum_r) * 51'(MEAN_RECIP);
  assign quo_ovf   = |div_quo[56:24];

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    if (state_r == S_DISP) begin
      if (calib_r) begin
        div_start = (sum_r != 21'd0);
        div_dvd   = {8'd0, num_r, 8'd0};
        div_dvs   = den_r;
      end else begin
        div_start = (sum_r != 21'd0) && (num_r != 41'd0);
        div_dvd   = {num_r, 16'd0};
        div_dvs   = den_r;
      end
    end
  end

  gspe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quo)
  );

  assign sq    = 62'(m_r) * 62'(m_r);
  assign sq_hi = sq[61:30];
  assign lval  = {lk_r, frac_r};
  assign l_c   = $signed({1'b0, lnum_r}) - $signed({1'b0, lval});
  assign bprod = cfg.b * $signed(gspe_pkg::LOG2_10_Q16);
  assign b2    = bprod[34:12];
  assign d_c   = {l_r[22], l_r} - {b2[22], b2};
  assign eprod = d_r * cfg.inv;
  assign e_c   = eprod[39:12];
  assign t_c   = {e_c[27], e_c} + gspe_pkg::EXP_OFFSET;

  assign bitv   = 64'd1 << {bi_r, 1'b0};
  assign cand   = sr_r + bitv;
  assign sq_ge  = (sx_r >= cand);
  assign sr_nxt = sq_ge ? (sr_r >> 1) + bitv : (sr_r >> 1);
  assign yd     = t_r[ei_r] ? {y_r, 1'b0} : {1'b0, y_r};
  assign shamt  = 5'd30 - t_r[20:16];
  assign ppm_c  = t_r[28] ? 24'd0 : 24'(y_r >> shamt);

  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign res_push  = (state_r == S_PUSH) && !res_full;
  assign res.ppm   = ppm_r;
  assign res.ratio = ratio_r;
  assign res.mean  = mean_r;
  assign res.sat   = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ref_r   <= 24'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            calib_r <= job.calib;
            sum_r   <= job.sum;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          diff_r  <= diff_c;
          mean_r  <= mean_prod[41:29];
          state_r <= S_MUL;
        end
        S_MUL: begin
          num_r   <= num_c;
          den_r   <= den_c;
          state_r <= S_DISP;
        end
        S_DISP: begin
          if (calib_r) begin
            if (sum_r == 21'd0) begin
              ref_r   <= gspe_pkg::MAX24;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_CDIV;
            end
          end else if (sum_r == 21'd0) begin
            ratio_r <= gspe_pkg::MAX24;
            ppm_r   <= gspe_pkg::MAX24;
            sat_r   <= 1'b1;
            state_r <= S_PUSH;
          end else if (num_r == 41'd0) begin
            ratio_r <= 24'd0;
            ppm_r   <= gspe_pkg::MAX24;
            sat_r   <= 1'b1;
            state_r <= S_PUSH;
          end else begin
            state_r <= S_RDIV;
          end
        end
        S_CDIV: begin
          if (div_done) begin
            ref_r   <= quo_ovf ? gspe_pkg::MAX24 : div_quo[23:0];
            state_r <= S_IDLE;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            ratio_r <= quo_ovf ? gspe_pkg::MAX24 : div_quo[23:0];
            sat_r   <= quo_ovf;
            lx_r    <= 48'(num_r);
            lk_r    <= 6'd47;
            lsel_r  <= 1'b0;
            state_r <= S_LNORM;
          end
        end
        S_LNORM: begin
          if (lx_r[47]) begin
            m_r     <= lx_r[47:17];
            li_r    <= 4'd15;
            frac_r  <= '0;
            state_r <= S_LSQ;
          end else begin
            lx_r <= {lx_r[46:0], 1'b0};
            lk_r <= lk_r - 6'd1;
          end
        end
        S_LSQ: begin
          if (sq_hi[31]) begin
            m_r          <= sq_hi[31:1];
            frac_r[li_r] <= 1'b1;
          end else begin
            m_r <= sq_hi[30:0];
          end
          if (li_r == 4'd0) begin
            state_r <= S_LEND;
          end else begin
            li_r <= li_r - 4'd1;
          end
        end
        S_LEND: begin
          if (!lsel_r) begin
            lnum_r  <= lval;
            lx_r    <= 48'(den_r);
            lk_r    <= 6'd47;
            lsel_r  <= 1'b1;
            state_r <= S_LNORM;
          end else begin
            l_r     <= l_c;
            state_r <= S_B2;
          end
        end
        S_B2: begin
          d_r     <= d_c;
          state_r <= S_EMUL;
        end
        S_EMUL: begin
          t_r     <= t_c;
          state_r <= S_ECHK;
        end
        S_ECHK: begin
          if (t_r >= gspe_pkg::EXP_LIMIT) begin
            ppm_r   <= gspe_pkg::MAX24;
            sat_r   <= 1'b1;
            state_r <= S_PUSH;
          end else begin
            y_r     <= 31'h40000000;
            ei_r    <= 4'd0;
            state_r <= S_XPRE;
          end
        end
        S_XPRE: begin
          sx_r    <= {2'b00, yd, 30'd0};
          sr_r    <= '0;
          bi_r    <= 5'd31;
          state_r <= S_XSQ;
        end
        S_XSQ: begin
          if (sq_ge) begin
            sx_r <= sx_r - cand;
          end
          sr_r <= sr_nxt;
          if (bi_r == 5'd0) begin
            y_r <= sr_nxt[30:0];
            if (ei_r == 4'd15) begin
              state_r <= S_XOUT;
            end else begin
              ei_r    <= ei_r + 4'd1;
              state_r <= S_XPRE;
            end
          end else begin
            bi_r <= bi_r - 5'd1;
          end
        end
        S_XOUT: begin
          ppm_r   <= ppm_c;
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/gas_sensor_ppm_estimator.sv -----
// Gas sensor ppm estimator top level: register file, accumulator, queues, evaluator
// Throughput: one sample per cycle while the group queue has room; the evaluation of a group
// is set mostly by the sixteen square-root steps of exp2, the ratio division and log2 shifts.
// Reset: synchronous; clears sums, counts, calibration, reference, queues; loads defaults.
module gas_sensor_ppm_estimator #(
  parameter int CALIB_SAMPLES   = 200,
  parameter int MEASURE_SAMPLES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [11:0] in_sample_mv,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] out_ppm_q4,
  output logic [23:0] out_ratio_q16,
  output logic [12:0] out_mean_mv,
  output logic        out_saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gspe_pkg::cfg_t    cfg_r;
  logic              div_en_r;
  gspe_pkg::reg_idx_t idx;
  logic              wr;
  gspe_pkg::job_t    job_in;
  gspe_pkg::job_t    job_out;
  logic              job_push;
  logic              job_full;
  logic              job_empty;
  logic              job_pop;
  gspe_pkg::result_t res_in;
  gspe_pkg::result_t res_out;
  logic              res_push;
  logic              res_full;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.supply <= 13'd5000;
      cfg_r.load   <= 20'd10000;
      cfg_r.cr     <= 16'd17920;
      cfg_r.b      <= 16'sd0;
      cfg_r.inv    <= -16'sd4096;
      div_en_r     <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        gspe_pkg::REG_SUPPLY:  cfg_r.supply <= pwdata[12:0];
        gspe_pkg::REG_LOAD:    cfg_r.load   <= pwdata[19:0];
        gspe_pkg::REG_CLEAN:   cfg_r.cr     <= pwdata[15:0];
        gspe_pkg::REG_ICEPT:   cfg_r.b      <= pwdata[15:0];
        gspe_pkg::REG_SLOPE:   cfg_r.inv    <= pwdata[15:0];
        gspe_pkg::REG_DIVIDER: div_en_r     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gspe_pkg::REG_SUPPLY:  prdata = 32'(cfg_r.supply);
      gspe_pkg::REG_LOAD:    prdata = 32'(cfg_r.load);
      gspe_pkg::REG_CLEAN:   prdata = 32'(cfg_r.cr);
      gspe_pkg::REG_ICEPT:   prdata = 32'(unsigned'(cfg_r.b));
      gspe_pkg::REG_SLOPE:   prdata = 32'(unsigned'(cfg_r.inv));
      gspe_pkg::REG_DIVIDER: prdata = 32'(div_en_r);
      default:               prdata = 32'd0;
    endcase
  end

  gspe_front #(
    .CALIB_SAMPLES   (CALIB_SAMPLES),
    .MEASURE_SAMPLES (MEASURE_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .divider_enable (div_en_r),
    .push           (push),
    .full           (full),
    .in_sample_mv   (in_sample_mv),
    .job_full       (job_full),
    .job_push       (job_push),
    .job            (job_in)
  );

  gspe_queue #(
    .W ($bits(gspe_pkg::job_t))
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  gspe_back #(
    .CALIB_SAMPLES   (CALIB_SAMPLES),
    .MEASURE_SAMPLES (MEASURE_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  gspe_queue #(
    .W ($bits(gspe_pkg::result_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_ppm_q4    = res_out.ppm;
  assign out_ratio_q16 = res_out.ratio;
  assign out_mean_mv   = res_out.mean;
  assign out_saturated = res_out.sat;

endmodule

// ----- rtl/core/gspe_checker.sv -----
// Port-level checker for the gas sensor ppm estimator and its bind
`include "assert_macros.svh"

module gspe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [23:0] out_ppm_q4,
  input logic [23:0] out_ratio_q16,
  input logic [12:0] out_mean_mv
);

  `CHK_ASSERT_RST(a_reset_empty, !rst_n |=> empty)
  `CHK_ASSERT(a_mean_range, !empty |-> out_mean_mv <= 13'd8190)
  `CHK_ASSERT(a_word_held, !empty && !pop |=> !empty)
  `CHK_ASSERT(a_word_stable, !empty && !pop |=> $stable(out_ppm_q4) && $stable(out_ratio_q16))

endmodule

bind gas_sensor_ppm_estimator gspe_checker u_gspe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .pop           (pop),
  .out_ppm_q4    (out_ppm_q4),
  .out_ratio_q16 (out_ratio_q16),
  .out_mean_mv   (out_mean_mv)
);

// ----- tb/gas_sensor_ppm_estimator_tb.sv -----
// Testbench for the gas sensor ppm estimator: scoreboard, queue drivers and phases
`timescale 1ns / 1ps

module gas_sensor_ppm_estimator_tb;

  localparam gspe_pkg::reg_idx_t REG_SPARE = 3'd6;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 1200;

  class ppm_scoreboard;
    logic [12:0] supply;
    logic [19:0] load;
    logic [15:0] clean_ratio;
    logic signed [15:0] icept;
    logic signed [15:0] inv_slope;
    logic divider;
    logic [20:0] acc_sum;
    logic [7:0] acc_count;
    logic calibrated;
    logic [23:0] r0_ohms;
    gspe_pkg::result_t expected_words[$];
    int errors;
    int mismatches;

    function new();
      supply = 13'd5000;
      load = 20'd10000;
      clean_ratio = 16'd17920;
      icept = 16'sd0;
      inv_slope = -16'sd4096;
      divider = 1'b0;
      acc_sum = '0;
      acc_count = '0;
      calibrated = 1'b0;
      r0_ohms = '0;
      errors = 0;
      mismatches = 0;
    endfunction

    function void write_reg(gspe_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        gspe_pkg::REG_SUPPLY: begin
          supply = v[12:0];
        end
        gspe_pkg::REG_LOAD: begin
          load = v[19:0];
        end
        gspe_pkg::REG_CLEAN: begin
          clean_ratio = v[15:0];
        end
        gspe_pkg::REG_ICEPT: begin
          icept = v[15:0];
        end
        gspe_pkg::REG_SLOPE: begin
          inv_slope = v[15:0];
        end
        gspe_pkg::REG_DIVIDER: begin
          divider = v[0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint log2_q16(longint unsigned x);
      int k;
      longint unsigned m;
      longint res;
      k = 63;
      while (k > 0 && x[k] == 1'b0) k--;
      m = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
      res = longint'(k) * 65536;
      for (int i = 15; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          res = res + (longint'(1) << i);
        end
      end
      return res;
    endfunction

    function longint unsigned exp2_q16(longint t);
      longint ip, sh;
      longint unsigned f, y;
      ip = t >>> 16;
      f = longint'(t - ip * 65536);
      y = 64'd1 << 30;
      for (int i = 0; i < 16; i++) begin
        if (f[i]) y = y << 1;
        y = int_sqrt(y << 30);
      end
      sh = 30 - ip;
      if (sh >= 63) return 0;
      return y >> sh;
    endfunction

    function void note_sample(logic [11:0] mv);
      longint unsigned s, n, sum, full_mv, num, den, r0, ratio, ppm, cr;
      longint l, b2, e, t;
      bit sat;
      gspe_pkg::result_t w;
      s = divider ? {mv, 1'b0} : mv;
      n = calibrated ? 10 : 200;
      acc_sum = acc_sum + s[20:0];
      acc_count = acc_count + 8'd1;
      if (acc_count < n) return;
      sum = acc_sum;
      acc_sum = '0;
      acc_count = '0;
      full_mv = longint'(supply) * n;
      num = (full_mv > sum) ? longint'(load) * (full_mv - sum) : 0;
      sat = 1'b0;
      if (!calibrated) begin
        cr = (clean_ratio != 0) ? clean_ratio : 1;
        if (sum == 0) begin
          r0 = gspe_pkg::MAX24;
        end else begin
          r0 = (num << 8) / (sum * cr);
          if (r0 > gspe_pkg::MAX24) r0 = gspe_pkg::MAX24;
        end
        r0_ohms = r0[23:0];
        calibrated = 1'b1;
        return;
      end
      r0 = (r0_ohms != 0) ? r0_ohms : 1;
      if (sum == 0) begin
        ratio = gspe_pkg::MAX24;
        ppm = gspe_pkg::MAX24;
        sat = 1'b1;
      end else if (num == 0) begin
        ratio = 0;
        ppm = gspe_pkg::MAX24;
        sat = 1'b1;
      end else begin
        den = sum * r0;
        ratio = (num << 16) / den;
        if (ratio > gspe_pkg::MAX24) begin
          ratio = gspe_pkg::MAX24;
          sat = 1'b1;
        end
        l = log2_q16(num) - log2_q16(den);
        b2 = (longint'(icept) * 217706) >>> 12;
        e = ((l - b2) * longint'(inv_slope)) >>> 12;
        t = e + 4 * 65536;
        if (t >= 24 * 65536) begin
          ppm = gspe_pkg::MAX24;
          sat = 1'b1;
        end else begin
          ppm = exp2_q16(t);
          if (ppm > gspe_pkg::MAX24) begin
            ppm = gspe_pkg::MAX24;
            sat = 1'b1;
          end
        end
      end
      w.ppm = ppm[23:0];
      w.ratio = ratio[23:0];
      w.mean = 13'(sum / 10);
      w.sat = sat;
      expected_words.push_back(w);
    endfunction

    function void check_result(gspe_pkg::result_t got);
      gspe_pkg::result_t exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected word: %p", got);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got !== exp_w) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: exp ppm %h ratio %h mean %0d sat %b, got %h %h %0d %b",
                   exp_w.ppm, exp_w.ratio, exp_w.mean, exp_w.sat,
                   got.ppm, got.ratio, got.mean, got.sat);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [11:0] in_sample_mv;
  logic [23:0] out_ppm_q4, out_ratio_q16;
  logic [12:0] out_mean_mv;
  logic out_saturated;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  ppm_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  gas_sensor_ppm_estimator i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_sample_mv(in_sample_mv),
    .empty(empty), .pop(pop), .out_ppm_q4(out_ppm_q4), .out_ratio_q16(out_ratio_q16),
    .out_mean_mv(out_mean_mv), .out_saturated(out_saturated), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        sb.check_result('{ppm: out_ppm_q4, ratio: out_ratio_q16, mean: out_mean_mv,
                          sat: out_saturated});
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(gspe_pkg::reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_sample(logic [11:0] mv);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_sample_mv <= mv;
    do @(posedge clk); while (full);
    sb.note_sample(mv);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(int count);
    int base, spread;
    base = $urandom_range(4095);
    spread = $urandom_range(64);
    for (int i = 0; i < count; i++) begin
      if (i % 10 == 0 && $urandom_range(3) == 0) begin
        base = $urandom_range(4095);
        spread = $urandom_range(64);
      end
      if ($urandom_range(9) == 0)
        send_sample(12'($urandom_range(4095)));
      else
        send_sample(12'(base + $urandom_range(2 * spread) - spread));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_sample_mv = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 200; i++) send_sample(12'(1800 + $urandom_range(400)));
    repeat (10) send_sample(12'd0);
    repeat (10) send_sample(12'd4095);
    for (int i = 0; i < 10; i++) send_sample(i[0] ? 12'd4095 : 12'd1);
    send_random(20);
    drain();

    for (int p = 1; p <= 10; p++) begin
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 59; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 59; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      case (p)
        1: begin
          write_reg(gspe_pkg::REG_SUPPLY, 32'd1);
          write_reg(gspe_pkg::REG_LOAD, 32'hFFFFF);
          write_reg(gspe_pkg::REG_CLEAN, 32'hFFFF);
          write_reg(gspe_pkg::REG_ICEPT, 32'h8000);
          write_reg(gspe_pkg::REG_SLOPE, 32'h7FFF);
          write_reg(gspe_pkg::REG_DIVIDER, 32'd1);
        end
        2: begin
          write_reg(gspe_pkg::REG_SUPPLY, 32'd8191);
          write_reg(gspe_pkg::REG_LOAD, 32'd1);
          write_reg(gspe_pkg::REG_CLEAN, 32'd0);
          write_reg(gspe_pkg::REG_ICEPT, 32'h7FFF);
          write_reg(gspe_pkg::REG_SLOPE, 32'h8000);
          write_reg(gspe_pkg::REG_DIVIDER, 32'd0);
        end
        3: begin
          write_reg(gspe_pkg::REG_SUPPLY, 32'd0);
          write_reg(gspe_pkg::REG_LOAD, 32'd0);
          write_reg(REG_SPARE, $urandom);
        end
        4: begin
          write_reg(gspe_pkg::REG_SUPPLY, 32'd5000);
          write_reg(gspe_pkg::REG_LOAD, 32'd10000);
          write_reg(gspe_pkg::REG_ICEPT, 32'd0);
          write_reg(gspe_pkg::REG_SLOPE, 32'hF000);
        end
        default: begin
          write_reg(gspe_pkg::REG_SUPPLY, $urandom_range(1, 8191));
          write_reg(gspe_pkg::REG_LOAD, $urandom);
          write_reg(gspe_pkg::REG_CLEAN, $urandom);
          if ($urandom_range(1)) begin
            write_reg(gspe_pkg::REG_ICEPT, 32'($urandom_range(8192) - 4096));
            write_reg(gspe_pkg::REG_SLOPE, 32'(-$urandom_range(8192, 1024)));
          end else begin
            write_reg(gspe_pkg::REG_ICEPT, $urandom);
            write_reg(gspe_pkg::REG_SLOPE, $urandom);
          end
          write_reg(gspe_pkg::REG_DIVIDER, $urandom);
        end
      endcase
      send_random(100);
      drain();
    end

    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
